### rtl/nru_pkg.sv
// Package: shared constants and types for the NRU cache lookup block.
`timescale 1ns / 1ps
package nru_pkg;
  localparam int unsigned AddrWidthDef = 32;
  localparam int unsigned MaxSetsDef   = 1024;
  localparam int unsigned MaxWaysDef   = 8;
  localparam int unsigned TagWidth     = 32;
  localparam int unsigned CfgWidth     = 5;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned SetOutWidth  = 10;
  localparam int unsigned CountWidth   = 32;

  localparam logic [CfgIdxWidth-1:0] RegOffsetBits = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegIndexBits  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegWaysInUse  = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StLookup
  } state_e;
endpackage

### rtl/nru_stream_if.sv
// Interface: valid/ready channel carrying one item of width W.
`timescale 1ns / 1ps
interface nru_stream_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/nru_ram.sv
// Generic synchronous RAM with one write port and one read port, registered read.
`timescale 1ns / 1ps
module nru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/nru_set_associative_cache_lookup_top.sv
// Top level: NRU set-associative tag lookup with a saturating miss count.
//
// Every access reads one set row (all ways: tags, marks and fill) from on-chip
// memory, compares all ways in parallel and writes the updated row back. An
// item is accepted in the idle state while its set row is read; in the lookup
// state the row is updated and written back, and the same step loads the result
// into the output register. The input is open again in the cycle after the
// write-back, so a new item is not taken before the last one is written back.
// A result held by the receiver keeps the next item waiting in its update step
// until the output register frees up. After reset a clearing pass zeroes the
// row memory, one set per cycle, through every set; no item is accepted during
// it.
// Input data is the address; output data is {miss_total, set_index, hit}.
`timescale 1ns / 1ps
module nru_set_associative_cache_lookup_top
  import nru_pkg::*;
#(
  parameter int unsigned AddrWidth = AddrWidthDef,
  parameter int unsigned MaxSets   = MaxSetsDef,
  parameter int unsigned MaxWays   = MaxWaysDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  nru_stream_if.sink             in_if,
  nru_stream_if.source           out_if
);
  localparam int unsigned SetW  = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int unsigned FillW = $clog2(MaxWays + 1);
  localparam int unsigned WayW  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned RowW  = MaxWays * (TagWidth + 1) + FillW;
  localparam int unsigned ExtW  = AddrWidth + 64;

  typedef struct packed {
    logic [MaxWays-1:0][TagWidth-1:0] tag;
    logic [MaxWays-1:0]               mark;
    logic [FillW-1:0]                 fill;
  } row_t;

  // configuration
  logic [4:0] offset_q;
  logic [3:0] index_q;
  logic [3:0] ways_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      index_q  <= '0;
      ways_q   <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOffsetBits: offset_q <= cfg_data_i;
        RegIndexBits:  index_q  <= cfg_data_i[3:0];
        RegWaysInUse:  ways_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [ExtW-1:0]     addr_ext, tag_sh;
  logic [ExtW-1:0]     idx_sh;
  logic [SetW-1:0]     set_c;
  logic [TagWidth-1:0] tag_c;
  logic [15:0]         idx_mask;
  always_comb begin
    addr_ext = {{64{1'b0}}, in_if.data[AddrWidth-1:0]};
    idx_sh   = addr_ext >> offset_q;
    idx_mask = 16'((17'd1 << index_q) - 17'd1);
    set_c    = SetW'(idx_sh[15:0] & idx_mask);
    if (MaxSets == 1) set_c = '0;
    tag_sh   = addr_ext >> (6'(offset_q) + 6'(index_q));
    tag_c    = tag_sh[TagWidth-1:0];
  end

  state_e              state_q, state_d;
  logic [SetW-1:0]     set_q;
  logic [TagWidth-1:0] tag_q;
  logic                hit_q;
  logic [CountWidth-1:0] miss_q, miss_d;
  logic [SetW:0]       clr_q;
  logic                clearing;
  logic                out_valid_q;
  logic [SetW-1:0]     res_set_q;
  logic                adv;
  assign clearing = !clr_q[SetW];

  // row memory; the address holds the item's set while it waits in lookup
  logic            we;
  logic [SetW-1:0] waddr, raddr;
  row_t            wrow, rrow, nrow;
  logic [RowW-1:0] rdata;
  assign rrow  = row_t'(rdata);
  assign raddr = (state_q == StIdle) ? set_c : set_q;

  nru_ram #(.Width(RowW), .Depth(MaxSets)) u_row_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (RowW'(wrow)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // row update
  logic [FillW-1:0] fill, ways;
  logic             hit_c, any_m;
  logic [WayW-1:0]  hpos, mpos, pos;
  always_comb begin
    ways = (ways_q == 4'd0) ? FillW'(1) :
           (32'(ways_q) > MaxWays) ? FillW'(MaxWays) : FillW'(ways_q);
    fill = (32'(rrow.fill) > MaxWays) ? FillW'(MaxWays) : rrow.fill;
    hit_c = 1'b0; any_m = 1'b0; hpos = '0; mpos = '0; pos = '0;
    for (int k = MaxWays - 1; k >= 0; k--) begin
      if (k < 32'(fill) && rrow.tag[k] == tag_q) begin
        hit_c = 1'b1; hpos = WayW'(k);
      end
      if (k < 32'(fill) && rrow.mark[k]) begin
        any_m = 1'b1; mpos = WayW'(k);
      end
    end
    nrow = rrow;
    nrow.fill = fill;
    if (hit_c) begin
      nrow.mark[hpos] = 1'b0;
    end else begin
      if (!any_m) begin
        for (int k = 0; k < MaxWays; k++)
          if (k < 32'(fill)) nrow.mark[k] = 1'b1;
      end
      pos = any_m ? mpos : '0;
      // shift from the back so each entry moves exactly one place
      if (fill < ways) begin
        for (int k = MaxWays - 1; k >= 1; k--)
          if (k > 32'(pos) && k <= 32'(fill)) begin
            nrow.tag[k]  = nrow.tag[k-1];
            nrow.mark[k] = nrow.mark[k-1];
          end
        nrow.fill = fill + FillW'(1);
      end
      nrow.tag[pos]  = tag_q;
      nrow.mark[pos] = 1'b0;
    end
    miss_d = miss_q;
    if (!hit_c && miss_q != '1) miss_d = miss_q + CountWidth'(1);
  end

  // control
  always_comb begin
    state_d      = state_q;
    in_if.ready  = 1'b0;
    we           = 1'b0;
    adv          = 1'b0;
    waddr        = set_q;
    wrow         = nrow;
    if (clearing) begin
      we = 1'b1; waddr = clr_q[SetW-1:0]; wrow = '0;
    end
    case (state_q)
      StIdle: begin
        in_if.ready = !clearing;
        if (in_if.valid && !clearing) state_d = StLookup;
      end
      StLookup: begin
        // write back only once the output register can take the result
        if (!out_valid_q || out_if.ready) begin
          adv     = 1'b1;
          we      = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
  assign out_if.valid = out_valid_q;
  assign out_if.data  = {miss_q, SetOutWidth'(res_set_q), hit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      miss_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (adv) begin
        miss_q      <= miss_d;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      set_q <= set_c;
      tag_q <= tag_c;
    end
    if (adv) begin
      hit_q     <= hit_c;
      res_set_q <= set_q;
    end
  end
endmodule
